/* rtl/core/tst_pkg.sv */
// ----------------------------------------------------------------------------
// tst_pkg: shared types and codes for the topic subscription table
// Opcodes, result status codes, command record and back-end state type.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int unsigned CLIENT_W = 22;
  localparam int unsigned TOPIC_W  = 16;

  typedef enum logic [1:0] {
    OP_SUB   = 2'd0,
    OP_UNSUB = 2'd1,
    OP_SEND  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_t;

  // one classified command handed from the front end to the back end
  typedef struct packed {
    op_t                 op;
    logic [CLIENT_W-1:0] client;
    logic [TOPIC_W-1:0]  topic;
  } cmd_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_SUB,
    BE_SCAN,
    BE_MOVE,
    BE_DONE
  } be_state_t;

endpackage

/* rtl/core/topic_subscription_table.sv */
// ----------------------------------------------------------------------------
// topic_subscription_table: subscription table for a publish/subscribe broker
// Stores (client, topic) pairs, removes by swap with the last entry, and
// lists the subscribers of a topic in slot order.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in_      | valid, stall, op, client_id, topic_key    | into block
//  out_     | valid, stall, dest_id, status, last       | out of block
//
// Subscribe passes through the command queue and the BE_SUB state to the output
// register. Unsubscribe and send walk the entry memory one slot a cycle through
// its single read port, unless an output stall holds a send. A two-deep command
// queue takes new items while the engine works. Reset empties the table at once;
// the unused opcode is dropped.
module topic_subscription_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_op,
  input  logic [tst_pkg::CLIENT_W-1:0] in_client_id,
  input  logic [tst_pkg::TOPIC_W-1:0]  in_topic_key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tst_pkg::CLIENT_W-1:0] out_dest_id,
  output logic [1:0]                   out_status,
  output logic                         out_last
);

  logic          cmd_valid, cmd_take;
  tst_pkg::cmd_t cmd;

  tst_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_client_id, .in_topic_key,
    .cmd_valid, .cmd_take, .cmd
  );

  tst_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_dest_id, .out_status, .out_last
  );

  // a non-delivery status always closes its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tst_pkg::ST_OK |-> out_last)
    else $error("non-ok status without last");

  a_zero_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tst_pkg::ST_OK |-> out_dest_id == '0)
    else $error("nonzero dest on failure result");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> !cmd_take)
    else $error("engine took two commands back to back");

endmodule

/* rtl/core/tst_front.sv */
// ----------------------------------------------------------------------------
// tst_front: input stage and command queue
// Accepts items, drops the unused opcode, and holds up to two commands.
// ----------------------------------------------------------------------------
module tst_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic [tst_pkg::CLIENT_W-1:0]        in_client_id,
  input  logic [tst_pkg::TOPIC_W-1:0]         in_topic_key,
  output logic                                cmd_valid,
  input  logic                                cmd_take,
  output tst_pkg::cmd_t                       cmd
);

  tst_pkg::cmd_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;
  tst_pkg::cmd_t inc;

  assign in_stall  = (cnt_r == 2'd2);
  assign inc.op     = tst_pkg::op_t'(in_op);
  assign inc.client = in_client_id;
  assign inc.topic  = in_topic_key;
  // drop the unused opcode here: it yields no result
  assign push      = in_valid && !in_stall && (inc.op != tst_pkg::OP_NONE);
  assign pop       = cmd_take && cmd_valid;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/core/tst_back.sv */
// ----------------------------------------------------------------------------
// tst_back: table engine holding the entry memory
// Walks it one slot a cycle for unsubscribe and send unless a stall holds a send.
// ----------------------------------------------------------------------------
module tst_back #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  output logic                                cmd_take,
  input  tst_pkg::cmd_t                       cmd,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tst_pkg::CLIENT_W-1:0]        out_dest_id,
  output logic [1:0]                          out_status,
  output logic                                out_last
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [tst_pkg::CLIENT_W-1:0] mem_c [TABLE_DEPTH];
  logic [tst_pkg::TOPIC_W-1:0]  mem_t [TABLE_DEPTH];

  tst_pkg::be_state_t state_r, state_nxt;
  tst_pkg::cmd_t      cur_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r, idx_nxt;   // slot being read this cycle
  logic               rd_v_r;           // read data valid for slot idx_r-1
  logic [tst_pkg::CLIENT_W-1:0] rd_c_r;
  logic [tst_pkg::TOPIC_W-1:0]  rd_t_r;
  logic [AW-1:0]      hit_r;            // unsubscribe slot to fill
  logic               hit_any_r;        // a send delivered or an unsubscribe matched at least once
  // pending delivered result, released when the next hit or the end is known
  logic               pend_r;
  logic [tst_pkg::CLIENT_W-1:0] pend_id_r;

  logic               ov_r;
  logic [tst_pkg::CLIENT_W-1:0] od_r;
  logic [1:0]         os_r;
  logic               ol_r;
  logic               oslot;            // output register free this cycle
  logic               ov_set;           // a result is loaded this cycle

  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [tst_pkg::CLIENT_W-1:0] wr_c;
  logic [tst_pkg::TOPIC_W-1:0]  wr_t;
  logic               scan_end;
  logic               match;
  logic               send_hold;

  assign out_valid   = ov_r;
  assign out_dest_id = od_r;
  assign out_status  = os_r;
  assign out_last    = ol_r;
  assign oslot       = !ov_r || !out_stall;

  assign scan_end = (idx_r == count_r);
  assign match = rd_v_r && (rd_t_r == cur_r.topic) &&
                 ((cur_r.op == tst_pkg::OP_SEND) || (rd_c_r == cur_r.client));

  assign send_hold = (state_r == tst_pkg::BE_SCAN) && (cur_r.op == tst_pkg::OP_SEND)
                     && !oslot && match && pend_r;

  assign ov_set = (state_r == tst_pkg::BE_SUB) || (state_r == tst_pkg::BE_DONE) ||
                  ((state_r == tst_pkg::BE_SCAN) && (cur_r.op == tst_pkg::OP_SEND) &&
                   match && pend_r && !send_hold);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tst_pkg::BE_IDLE:
        if (cmd_valid) begin
          state_nxt = (cmd.op == tst_pkg::OP_SUB) ? tst_pkg::BE_SUB : tst_pkg::BE_SCAN;
        end
      tst_pkg::BE_SUB:  if (oslot) state_nxt = tst_pkg::BE_IDLE;
      tst_pkg::BE_SCAN:
        if (cur_r.op == tst_pkg::OP_UNSUB) begin
          if (match) state_nxt = tst_pkg::BE_MOVE;
          else if (scan_end && !rd_v_r) state_nxt = tst_pkg::BE_DONE;
        end else if (oslot && scan_end && !rd_v_r) begin
          state_nxt = tst_pkg::BE_DONE;
        end
      tst_pkg::BE_MOVE: if (rd_v_r) state_nxt = tst_pkg::BE_DONE;
      tst_pkg::BE_DONE: if (oslot) state_nxt = tst_pkg::BE_IDLE;
      default: state_nxt = tst_pkg::BE_IDLE;
    endcase
  end

  // outputs of the state machine: memory port control and scan advance
  always_comb begin
    cmd_take = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_r[AW-1:0];
    idx_nxt  = idx_r;
    mem_we   = 1'b0;
    wr_addr  = count_r[AW-1:0];
    wr_c     = cur_r.client;
    wr_t     = cur_r.topic;
    case (state_r)
      tst_pkg::BE_IDLE: begin
        cmd_take = cmd_valid;
        idx_nxt  = '0;
      end
      tst_pkg::BE_SUB:
        mem_we = oslot && (count_r != DEPTH_C);
      tst_pkg::BE_SCAN: begin
        // a send holds while a delivered result waits for the output slot
        if (!scan_end && ((cur_r.op == tst_pkg::OP_UNSUB && !match) ||
            (cur_r.op == tst_pkg::OP_SEND && (oslot || !(match && pend_r))))) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (cur_r.op == tst_pkg::OP_UNSUB && match) begin
          rd_en   = 1'b1;
          rd_addr = AW'(count_r - 1'b1);
        end
      end
      tst_pkg::BE_MOVE: begin
        mem_we  = rd_v_r;
        wr_addr = hit_r;
        wr_c    = rd_c_r;
        wr_t    = rd_t_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_c[wr_addr] <= wr_c;
      mem_t[wr_addr] <= wr_t;
    end
    if (rd_en) begin
      rd_c_r <= mem_c[rd_addr];
      rd_t_r <= mem_t[rd_addr];
    end
    if (cmd_take) cur_r <= cmd;
    if (state_r == tst_pkg::BE_SCAN && match && !send_hold) begin
      hit_r <= AW'(idx_r - 1'b1);
      pend_id_r <= rd_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tst_pkg::BE_IDLE;
      count_r   <= '0;
      idx_r     <= '0;
      rd_v_r    <= 1'b0;
      pend_r    <= 1'b0;
      hit_any_r <= 1'b0;
      ov_r      <= 1'b0;
      od_r      <= '0;
      os_r      <= '0;
      ol_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (!send_hold) rd_v_r <= rd_en;
      if (oslot) ov_r <= ov_set;
      case (state_r)
        tst_pkg::BE_IDLE: begin
          pend_r    <= 1'b0;
          hit_any_r <= 1'b0;
        end
        tst_pkg::BE_SUB:
          if (oslot) begin
            od_r <= '0;
            ol_r <= 1'b1;
            if (count_r != DEPTH_C) begin
              os_r    <= tst_pkg::ST_OK;
              count_r <= count_r + 1'b1;
            end else begin
              os_r <= tst_pkg::ST_FULL;
            end
          end
        tst_pkg::BE_SCAN:
          if (cur_r.op == tst_pkg::OP_SEND && !send_hold) begin
            if (match) begin
              pend_r    <= 1'b1;
              hit_any_r <= 1'b1;
              if (pend_r) begin
                od_r <= pend_id_r;
                os_r <= tst_pkg::ST_OK;
                ol_r <= 1'b0;
              end
            end
          end else if (cur_r.op == tst_pkg::OP_UNSUB && match) begin
            hit_any_r <= 1'b1;
          end
        tst_pkg::BE_MOVE:
          if (rd_v_r) count_r <= count_r - 1'b1;
        tst_pkg::BE_DONE:
          if (oslot) begin
            ol_r <= 1'b1;
            if (cur_r.op == tst_pkg::OP_SEND) begin
              od_r <= hit_any_r ? pend_id_r : '0;
              os_r <= hit_any_r ? tst_pkg::ST_OK : tst_pkg::ST_NOMATCH;
            end else begin
              od_r <= '0;
              os_r <= hit_any_r ? tst_pkg::ST_OK : tst_pkg::ST_NOTFOUND;
            end
          end
        default: ;
      endcase
    end
  end

endmodule

/* sim/topic_subscription_table_tb.sv */
// ----------------------------------------------------------------------------
// topic_subscription_table_tb: self-checking bench for the subscription table
// Drives subscribe, unsubscribe and send commands with random gaps and output
// stalls, predicts every result from a shadow table and checks in order.
// ----------------------------------------------------------------------------
module topic_subscription_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int WATCH_LIMIT = 20000;
  localparam int CLW = tst_pkg::CLIENT_W;
  localparam int TPW = tst_pkg::TOPIC_W;

  typedef struct {
    logic [1:0]     op;
    logic [CLW-1:0] client;
    logic [TPW-1:0] topic;
  } cmd_item_t;

  typedef struct {
    logic [CLW-1:0]   dest;
    tst_pkg::status_t status;
    logic             last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic [CLW-1:0] in_client_id = '0;
  logic [TPW-1:0] in_topic_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CLW-1:0] out_dest_id;
  logic [1:0] out_status;
  logic out_last;

  cmd_item_t pending_cmds[$];
  reply_t expected_replies[$];
  logic [CLW-1:0] shadow_client[DEPTH];
  logic [TPW-1:0] shadow_topic[DEPTH];
  int shadow_count = 0;
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int cmds_sent = 0;
  int replies_seen = 0;
  logic [TPW-1:0] topic_pool[4];
  logic [CLW-1:0] client_pool[4];

  always #2 clk = ~clk;

  topic_subscription_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_client_id(in_client_id), .in_topic_key(in_topic_key),
    .out_valid(out_valid), .out_stall(out_stall), .out_dest_id(out_dest_id),
    .out_status(out_status), .out_last(out_last)
  );

  function automatic reply_t mk_reply(logic [CLW-1:0] d, tst_pkg::status_t s, logic l);
    reply_t r;
    r.dest = d;
    r.status = s;
    r.last = l;
    return r;
  endfunction

  // advance the shadow table by one command and queue its replies
  task automatic apply_command(cmd_item_t c);
    int hits;
    bit found;
    hits = 0;
    found = 0;
    case (c.op)
      tst_pkg::OP_SUB: begin
        if (shadow_count >= DEPTH) begin
          expected_replies.push_back(mk_reply('0, tst_pkg::ST_FULL, 1'b1));
        end else begin
          shadow_client[shadow_count] = c.client;
          shadow_topic[shadow_count] = c.topic;
          shadow_count++;
          expected_replies.push_back(mk_reply('0, tst_pkg::ST_OK, 1'b1));
        end
      end
      tst_pkg::OP_UNSUB: begin
        for (int i = 0; i < shadow_count && !found; i++) begin
          if (shadow_client[i] == c.client && shadow_topic[i] == c.topic) begin
            shadow_client[i] = shadow_client[shadow_count-1];
            shadow_topic[i] = shadow_topic[shadow_count-1];
            shadow_count--;
            found = 1;
          end
        end
        expected_replies.push_back(mk_reply('0,
          found ? tst_pkg::ST_OK : tst_pkg::ST_NOTFOUND, 1'b1));
      end
      tst_pkg::OP_SEND: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_topic[i] == c.topic) begin
            expected_replies.push_back(mk_reply(shadow_client[i], tst_pkg::ST_OK, 1'b0));
            hits++;
          end
        end
        if (hits == 0) expected_replies.push_back(mk_reply('0, tst_pkg::ST_NOMATCH, 1'b1));
        else expected_replies[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_item_t mk_cmd(logic [1:0] op, logic [CLW-1:0] cl,
                                       logic [TPW-1:0] tp);
    cmd_item_t c;
    c.op = op;
    c.client = cl;
    c.topic = tp;
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(mk_cmd(in_op, in_client_id, in_topic_key));
        cmds_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_valid <= 1'b1;
          in_op <= pending_cmds[0].op;
          in_client_id <= pending_cmds[0].client;
          in_topic_key <= pending_cmds[0].topic;
          void'(pending_cmds.pop_front());
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", int'(out_dest_id), 0);
        end else begin
          reply_t e;
          e = expected_replies.pop_front();
          if (out_dest_id !== e.dest)
            report_mismatch("dest_id", int'(out_dest_id), int'(e.dest));
          if (out_status !== e.status)
            report_mismatch("status", int'(out_status), int'(e.status));
          if (out_last !== e.last)
            report_mismatch("last", int'(out_last), int'(e.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCH_LIMIT);
        $display("topic_subscription_table_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int r;
    logic [1:0] op;
    for (int i = 0; i < 4; i++) begin
      topic_pool[i] = TPW'($urandom);
      client_pool[i] = CLW'($urandom);
    end
    // directed: empty table, extremes, duplicates, full table, op 3
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SEND, '1, 16'h0000));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_UNSUB, '0, 16'h0000));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SUB, '1, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SUB, '0, 16'h0000));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SUB, 22'h2AAAAA, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SUB, '1, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SEND, 22'h155555, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_NONE, '1, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_UNSUB, '1, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SEND, '0, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_UNSUB, '1, 16'h1234));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_UNSUB, '0, 16'h0000));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SEND, '0, 16'h0000));
    for (int i = 0; i < DEPTH + 2; i++)
      pending_cmds.push_back(mk_cmd(tst_pkg::OP_SUB, CLW'($urandom),
                                    i[1] ? 16'hFFFF : topic_pool[0]));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SEND, '0, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(tst_pkg::OP_SEND, '0, topic_pool[0]));
    // random: mostly drawn from small pools of clients and topics
    for (int i = 0; i < 200; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 40) ? tst_pkg::OP_SUB : (r < 65) ? tst_pkg::OP_UNSUB :
           (r < 95) ? tst_pkg::OP_SEND : tst_pkg::OP_NONE;
      if ($urandom_range(0, 9) < 8)
        pending_cmds.push_back(mk_cmd(op, client_pool[$urandom_range(0, 3)],
                                      topic_pool[$urandom_range(0, 3)]));
      else
        pending_cmds.push_back(mk_cmd(op, CLW'($urandom), TPW'($urandom)));
      // occasionally queue a burst of unsubscribes over the client and topic pools
      if (i % 120 == 60)
        for (int k = 0; k < 40; k++)
          pending_cmds.push_back(mk_cmd(tst_pkg::OP_UNSUB, client_pool[k % 4],
                                        topic_pool[(k/4) % 4]));
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_valid);
    wait (expected_replies.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d commands and %0d replies with random gaps and stalls",
             cmds_sent, replies_seen);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("topic_subscription_table_tb: clean");
    end else begin
      $display("%0d mismatches, %0d replies outstanding", errors, expected_replies.size());
      $display("topic_subscription_table_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tst_pkg.sv
rtl/core/tst_front.sv
rtl/core/tst_back.sv
rtl/core/topic_subscription_table.sv
sim/topic_subscription_table_tb.sv
